// ----- hdl/mqsb_pkg.sv -----
// ----------------------------------------------------------------------------
// mqsb_pkg: shared definitions for the multi-queue shared buffer
// sizes, codes and the controller-to-datapath command group
// ----------------------------------------------------------------------------
package mqsb_pkg;

  localparam int ENTRIES    = 16;
  localparam int QUEUES     = 4;
  localparam int DATA_WIDTH = 32;
  localparam int OUT_WIDTH  = 32;
  localparam int QID_W      = 2;

  // slot pointers carry one extra code: ENTRIES means null
  localparam int SLOT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W  = $clog2(ENTRIES);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam slot_t NULL_SLOT = slot_t'(ENTRIES);

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  // controller commands to the datapath
  typedef struct packed {
    logic capture;  // register the item and issue the link/payload reads
    logic commit;   // update pointers and links, load the result register
  } dp_cmd_t;

endpackage

// ----- hdl/mqsb_ctrl.sv -----
// ----------------------------------------------------------------------------
// mqsb_ctrl: sequencing for the multi-queue shared buffer
// two-state controller, owns input ready and result valid
// ----------------------------------------------------------------------------
module mqsb_ctrl
  import mqsb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t dp_cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    dp_cmd.capture = 1'b0;
    dp_cmd.commit  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          dp_cmd.capture = 1'b1;
          state_nxt      = S_UPD;
        end
      end
      S_UPD: begin
        // result register must be free, or emptied in this cycle
        if (!out_valid_r || out_tready) begin
          dp_cmd.commit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && !out_tready) || dp_cmd.commit;
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- hdl/mqsb_dpath.sv -----
// ----------------------------------------------------------------------------
// mqsb_dpath: pointers, link store and payload store
// queue head/tail registers, free list head, link and payload memories
// ----------------------------------------------------------------------------
module mqsb_dpath
  import mqsb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               dp_cmd,
  input  logic                  in_cmd,
  input  logic [QID_W-1:0]      in_queue_id,
  input  logic [DATA_WIDTH-1:0] in_data,
  output logic [OUT_WIDTH-1:0]  out_data,
  output logic [1:0]            out_status
);

  slot_t head_r [QUEUES];
  slot_t tail_r [QUEUES];
  slot_t free_head_r;

  slot_t                 link_mem [ENTRIES];
  logic  [ENTRIES-1:0]   link_vld_r;
  slot_t                 link_rd_r;
  logic [DATA_WIDTH-1:0] pay_mem [ENTRIES];
  logic [DATA_WIDTH-1:0] pay_rd_r;

  logic                  cmd_r;
  logic [QID_W-1:0]      qid_r;
  logic [DATA_WIDTH-1:0] data_r;

  logic [OUT_WIDTH-1:0]  out_data_r;
  status_t               out_status_r;

  // read address for the accept cycle
  slot_t rd_slot;
  idx_t  rd_idx;

  // commit-cycle decode
  logic  q_ok, head_ok, free_ok, enq_ok, deq_ok;
  slot_t head_q, tail_q;
  logic  lnk_we;
  idx_t  lnk_wa;
  slot_t lnk_wd;
  logic [OUT_WIDTH-1:0] res_data;
  status_t              res_status;

  assign rd_slot = (cmd_t'(in_cmd) == CMD_DEQ) ? head_r[in_queue_id] : free_head_r;
  assign rd_idx  = rd_slot[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_r     <= in_cmd;
      qid_r     <= in_queue_id;
      data_r    <= in_data;
      // a never-written link word reads as its reset value: next slot up
      link_rd_r <= link_vld_r[rd_idx] ? link_mem[rd_idx]
                                      : slot_t'(rd_idx) + slot_t'(1);
      pay_rd_r  <= pay_mem[rd_idx];
    end
  end

  always_comb begin
    q_ok    = (int'(qid_r) < QUEUES);
    head_q  = head_r[qid_r];
    tail_q  = tail_r[qid_r];
    head_ok = (head_q < NULL_SLOT);
    free_ok = (free_head_r < NULL_SLOT);
    enq_ok  = (cmd_t'(cmd_r) == CMD_ENQ) && q_ok && free_ok;
    deq_ok  = (cmd_t'(cmd_r) == CMD_DEQ) && q_ok && head_ok;

    lnk_we = 1'b0;
    lnk_wa = '0;
    lnk_wd = NULL_SLOT;
    if (enq_ok && head_ok) begin
      // append behind the current tail
      lnk_we = 1'b1;
      lnk_wa = tail_q[IDX_W-1:0];
      lnk_wd = free_head_r;
    end else if (deq_ok) begin
      // freed slot goes on the front of the free list
      lnk_we = 1'b1;
      lnk_wa = head_q[IDX_W-1:0];
      lnk_wd = free_head_r;
    end

    if (cmd_t'(cmd_r) == CMD_ENQ) begin
      res_data   = '0;
      res_status = enq_ok ? ST_OK : ST_FULL;
    end else if (deq_ok) begin
      res_data   = OUT_WIDTH'(pay_rd_r);
      res_status = ST_OK;
    end else begin
      res_data   = '1;
      res_status = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUES; i++) begin
        head_r[i] <= NULL_SLOT;
        tail_r[i] <= NULL_SLOT;
      end
      free_head_r <= '0;
      link_vld_r  <= '0;
    end else if (dp_cmd.commit) begin
      if (enq_ok) begin
        free_head_r   <= link_rd_r;
        tail_r[qid_r] <= free_head_r;
        if (!head_ok) begin
          head_r[qid_r] <= free_head_r;
        end
      end else if (deq_ok) begin
        // the tail slot ends the chain, so its link word is never needed
        head_r[qid_r] <= (head_q == tail_q) ? NULL_SLOT : link_rd_r;
        free_head_r   <= head_q;
      end
      if (lnk_we) begin
        link_vld_r[lnk_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      if (lnk_we) begin
        link_mem[lnk_wa] <= lnk_wd;
      end
      if (enq_ok) begin
        pay_mem[free_head_r[IDX_W-1:0]] <= data_r;
      end
      out_data_r   <= res_data;
      out_status_r <= res_status;
    end
  end

  assign out_data   = out_data_r;
  assign out_status = out_status_r;

endmodule

// ----- hdl/multi_queue_shared_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_unit: several fifo queues in one shared store
// enqueue/dequeue commands over a linked slot store with a free list
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                          | tuser
//  --------+-----+--------------------------------+----------------------
//  in_     | in  | [1:0] queue_id, [33:2] data_in | [0] cmd (0 enq, 1 deq)
//  out_    | out | [31:0] data_out                | [1:0] status
//
//  an item passes the accept state, which issues the registered reads of
//  the link word and payload slot, then the update state, which writes at
//  most one link word and the pointers and loads the result register
//  the link memory's single read-then-write round trip sets these two steps
//  a new item is taken while the previous result still waits; a result
//  that is not taken holds the commit cycle of the following item
//  reset (rst_n low, synchronous) empties every queue and rebuilds the
//  free list at once through per-slot link valid bits: no clearing pass
//
module multi_queue_shared_buffer_unit
  import mqsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] queue_id, [33:2] data_in, rest zero
  input  logic [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] data_out
  output logic [1:0]  out_tuser   // [1:0] status
);

  dp_cmd_t dp_cmd;

  // sequencing: ready, result valid and datapath commands
  mqsb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_cmd     (dp_cmd)
  );

  // pointers, link and payload stores, result register
  mqsb_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .dp_cmd      (dp_cmd),
    .in_cmd      (in_tuser[0]),
    .in_queue_id (in_tdata[QID_W-1:0]),
    .in_data     (in_tdata[QID_W+DATA_WIDTH-1:QID_W]),
    .out_data    (out_tdata),
    .out_status  (out_tuser)
  );

  // an accepted transfer is always followed by a busy cycle
  a_busy_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.capture |=> !in_tready)
    else $error("input taken while the previous item is in flight");

  // a commit always presents its result
  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.commit |=> out_tvalid)
    else $error("commit without a result");

  // commit never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.commit |-> (!out_tvalid || out_tready))
    else $error("result overwritten before transfer");

  // capture and commit never coincide
  a_exclusive_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(dp_cmd.capture && dp_cmd.commit))
    else $error("capture and commit in the same cycle");

endmodule
